[design/smp_pkg.sv]
// Shared types, codes and constants for the S-curve move planner.
package smp_pkg;

  localparam int BISECT_STEPS = 60;
  localparam int BIS_CNT_W    = $clog2(BISECT_STEPS);
  localparam int DIV_STEPS    = 48;
  localparam int SQRT_STEPS   = 24;
  localparam int ALU_CNT_W    = 6;

  localparam logic [31:0] QMAX = 32'hFFFF_FFFF;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_STRETCH    = 2'd1,
    ST_BAD_LIMITS = 2'd2,
    ST_BOUNDARY   = 2'd3
  } plan_status_t;

  typedef enum logic [1:0] {
    REG_VLIM = 2'd0,
    REG_ALIM = 2'd1,
    REG_DLIM = 2'd2,
    REG_JLIM = 2'd3
  } reg_index_t;

  typedef enum logic [2:0] {
    OP_ADD, OP_SUB, OP_MUL, OP_MUL17, OP_DIV, OP_SQRT
  } alu_op_t;

  typedef enum logic [1:0] {
    A_IDLE, A_MUL, A_DIV, A_SQRT
  } alu_state_t;

  typedef enum logic [4:0] {
    S_IDLE, S_CHK, S_SINGLE, S_P_AA, S_P_VTRI, S_P_TJA,
    S_E_JV, S_E_SQ, S_E_TJ, S_E_T1, S_E_T2, S_E_DACC, S_E_D2,
    S_E_DC, S_E_TC, S_E_M1, S_E_M2, S_RET, S_EMIT
  } seq_state_t;

  typedef enum logic [2:0] {
    PH_CEIL0, PH_BIS1, PH_TMIN, PH_BIS2, PH_FINAL
  } phase_t;

  typedef struct packed {
    alu_op_t     op;
    logic [31:0] a;
    logic [31:0] b;
  } alu_cmd_t;

  typedef struct packed {
    logic signed [31:0] start_position;
    logic signed [31:0] target_position;
    logic signed [31:0] wanted_time;
    logic signed [31:0] end_velocity;
    logic signed [31:0] end_acceleration;
  } plan_in_t;

  typedef struct packed {
    logic [2:0]         segment_index;
    logic [30:0]        duration;
    logic signed [31:0] start_accel;
    logic signed [31:0] segment_jerk;
    logic [1:0]         plan_status;
    logic [30:0]        planned_time;
    logic [2:0]         segment_total;
    logic               last;
  } plan_out_t;

  function automatic logic [30:0] sat31(input logic [31:0] x);
    sat31 = x[31] ? 31'h7FFF_FFFF : x[30:0];
  endfunction

endpackage

[design/smp_alu.sv]
// Shared saturating Q16.16 unit: add, subtract, multiply, iterative divide and square root.
module smp_alu (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  smp_pkg::alu_cmd_t cmd,
  output logic              done,
  output logic [31:0]       result
);
  import smp_pkg::*;

  alu_state_t           astate, astate_next;
  alu_op_t              mode;
  logic [63:0]          prod;
  logic [47:0]          nreg;
  logic [31:0]          rem;
  logic [31:0]          divisor;
  logic [47:0]          quo;
  logic [26:0]          srem;
  logic [23:0]          root;
  logic [ALU_CNT_W-1:0] cnt;

  logic [32:0] sum;
  logic [32:0] rem_sh;
  logic        dge;
  logic [31:0] rem_new;
  logic [47:0] quo_new;
  logic [26:0] srem_sh;
  logic [26:0] trial;
  logic        sge;
  logic [23:0] root_new;

  assign sum      = {1'b0, cmd.a} + {1'b0, cmd.b};
  assign rem_sh   = {rem, nreg[47]};
  assign dge      = rem_sh >= {1'b0, divisor};
  assign rem_new  = dge ? 32'(rem_sh - {1'b0, divisor}) : rem_sh[31:0];
  assign quo_new  = {quo[46:0], dge};
  assign srem_sh  = {srem[24:0], nreg[47:46]};
  assign trial    = {1'b0, root, 2'b01};
  assign sge      = srem_sh >= trial;
  assign root_new = {root[22:0], sge};

  always_comb begin
    astate_next = astate;
    case (astate)
      A_IDLE: begin
        if (start) begin
          case (cmd.op)
            OP_MUL, OP_MUL17: astate_next = A_MUL;
            OP_DIV:           astate_next = (cmd.b == '0) ? A_IDLE : A_DIV;
            OP_SQRT:          astate_next = A_SQRT;
            default:          astate_next = A_IDLE;
          endcase
        end
      end
      A_MUL:   astate_next = A_IDLE;
      A_DIV:   if (cnt == ALU_CNT_W'(DIV_STEPS - 1)) astate_next = A_IDLE;
      A_SQRT:  if (cnt == ALU_CNT_W'(SQRT_STEPS - 1)) astate_next = A_IDLE;
      default: astate_next = A_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      astate <= A_IDLE;
      done   <= 1'b0;
    end else begin
      astate <= astate_next;
      done   <= 1'b0;
      case (astate)
        A_IDLE: begin
          if (start) begin
            mode <= cmd.op;
            cnt  <= '0;
            case (cmd.op)
              OP_ADD: begin
                result <= sum[32] ? QMAX : sum[31:0];
                done   <= 1'b1;
              end
              OP_SUB: begin
                result <= (cmd.a > cmd.b) ? cmd.a - cmd.b : '0;
                done   <= 1'b1;
              end
              OP_MUL, OP_MUL17: prod <= 64'(cmd.a) * 64'(cmd.b);
              OP_DIV: begin
                if (cmd.b == '0) begin
                  result <= QMAX;
                  done   <= 1'b1;
                end
                nreg    <= {cmd.a, 16'h0000};
                rem     <= '0;
                quo     <= '0;
                divisor <= cmd.b;
              end
              OP_SQRT: begin
                nreg <= {cmd.a, 16'h0000};
                srem <= '0;
                root <= '0;
              end
              default: ;
            endcase
          end
        end
        A_MUL: begin
          if (mode == OP_MUL17) result <= (prod[63:49] != '0) ? QMAX : prod[48:17];
          else                  result <= (prod[63:48] != '0) ? QMAX : prod[47:16];
          done <= 1'b1;
        end
        A_DIV: begin
          rem  <= rem_new;
          quo  <= quo_new;
          nreg <= {nreg[46:0], 1'b0};
          cnt  <= cnt + 1'b1;
          if (cnt == ALU_CNT_W'(DIV_STEPS - 1)) begin
            result <= (quo_new[47:32] != '0) ? QMAX : quo_new[31:0];
            done   <= 1'b1;
          end
        end
        A_SQRT: begin
          srem <= sge ? srem_sh - trial : srem_sh;
          root <= root_new;
          nreg <= {nreg[45:0], 2'b00};
          cnt  <= cnt + 1'b1;
          if (cnt == ALU_CNT_W'(SQRT_STEPS - 1)) begin
            result <= {8'h00, root_new};
            done   <= 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  property p_mul_done;
    @(posedge clk) disable iff (rst) (astate == A_MUL) |=> done;
  endproperty
  a_mul_done: assert property (p_mul_done) else $error("multiply did not finish");

  property p_busy_no_done;
    @(posedge clk) disable iff (rst) (astate == A_DIV && cnt == '0) |=> !done;
  endproperty
  a_busy_no_done: assert property (p_busy_no_done) else $error("early divide done");

  property p_sqrt_bound;
    @(posedge clk) disable iff (rst) done && mode == OP_SQRT |-> result[31:24] == '0;
  endproperty
  a_sqrt_bound: assert property (p_sqrt_bound) else $error("root too wide");

endmodule

[design/scurve_move_planner.sv]
// Top level: jerk-limited seven-segment move planner with sequencer and output stage.
// Each step runs on the one shared unit and is issued only when the unit is free. A plan runs
// its setup steps and then up to 2*BISECT_STEPS+3 trial evaluations. Error and null moves
// skip the planning and answer with a single result.
// One plan at a time: busy holds from acceptance until the last strobe goes out; results
// cannot be stalled. Synchronous reset clears all limits to zero and returns to idle.
module scurve_move_planner (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  smp_pkg::plan_in_t  cmd,
  output logic               strobe,
  output smp_pkg::plan_out_t result,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data
);
  import smp_pkg::*;

  // limit registers
  logic [30:0] vlim, alim, dlim, jlim;

  seq_state_t state, state_next;
  phase_t     phase;
  plan_in_t   cmd_r;
  logic [1:0] status;
  logic       stretched;
  logic       neg;
  logic       tri_shape;
  logic       issued;
  logic [2:0] seg;
  logic [BIS_CNT_W-1:0] cnt;

  // datapath registers, all unsigned Q16.16
  logic [31:0] d, vtri, tja, ev, lo, hi, vceil;
  logic [31:0] t0, ap, tj, ta, tacc, dacc, d2, dc, q, mt;

  alu_cmd_t    acmd;
  logic        alu_start, alu_need, alu_done;
  logic [31:0] alu_res;

  smp_alu u_alu (
    .clk    (clk),
    .rst    (rst),
    .start  (alu_start),
    .cmd    (acmd),
    .done   (alu_done),
    .result (alu_res)
  );

  logic [31:0] amin, jw;
  logic signed [32:0] diff;
  logic [31:0] dcalc;
  logic        bad, bnd;
  logic        reqpos;
  logic [31:0] requ;
  logic [31:0] tcsel;
  logic [31:0] nlo, nhi, nmid;
  logic        bis_end;

  assign amin   = {1'b0, (alim < dlim) ? alim : dlim};
  assign jw     = {1'b0, jlim};
  assign bad    = (vlim == '0) || (amin == '0) || (jlim == '0);
  assign bnd    = (cmd_r.end_velocity != '0) || (cmd_r.end_acceleration != '0);
  assign diff   = 33'(cmd_r.target_position) - 33'(cmd_r.start_position);
  assign dcalc  = diff[32] ? 32'(-diff) : diff[31:0];
  assign reqpos = cmd_r.wanted_time > 0;
  assign requ   = 32'(cmd_r.wanted_time);
  assign busy   = (state != S_IDLE);

  // cruise time: zero on zero distance (final: on zero velocity, as the divide saturates)
  always_comb begin
    if (phase == PH_FINAL) tcsel = (ev == '0) ? '0 : q;
    else                   tcsel = (dc == '0) ? '0 : q;
  end

  // bisection update for the evaluation just finished
  always_comb begin
    nlo = lo;
    nhi = hi;
    if (phase == PH_BIS1) begin
      if (d2 < d) nlo = ev; else nhi = ev;
    end else begin
      if (mt > requ) nlo = ev; else nhi = ev;
    end
    nmid    = 32'((33'(nlo) + 33'(nhi)) >> 1);
    bis_end = (cnt == BIS_CNT_W'(BISECT_STEPS - 1));
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (start) state_next = S_CHK;
      S_CHK:    state_next = (bad || bnd || dcalc == '0) ? S_SINGLE : S_P_AA;
      S_SINGLE: state_next = S_IDLE;
      S_P_AA:   if (alu_done) state_next = S_P_VTRI;
      S_P_VTRI: if (alu_done) state_next = S_P_TJA;
      S_P_TJA:  if (alu_done) state_next = S_E_JV;
      S_E_JV:   if (alu_done) state_next = S_E_SQ;
      S_E_SQ:   if (alu_done) state_next = tri_shape ? S_E_TJ : S_E_T1;
      S_E_TJ:   if (alu_done) state_next = S_E_T1;
      S_E_T1:   if (alu_done) state_next = S_E_T2;
      S_E_T2:   if (alu_done) state_next = S_E_DACC;
      S_E_DACC: if (alu_done) state_next = S_E_D2;
      S_E_D2: begin
        if (alu_done) begin
          state_next = (phase == PH_CEIL0 || phase == PH_BIS1) ? S_RET : S_E_DC;
        end
      end
      S_E_DC:   if (alu_done) state_next = S_E_TC;
      S_E_TC:   if (alu_done) state_next = S_E_M1;
      S_E_M1:   if (alu_done) state_next = S_E_M2;
      S_E_M2:   if (alu_done) state_next = S_RET;
      S_RET:    state_next = (phase == PH_FINAL) ? S_EMIT : S_E_JV;
      S_EMIT:   if (seg == 3'd6) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // command to the shared unit for each step
  always_comb begin
    acmd     = '{op: OP_ADD, a: '0, b: '0};
    alu_need = 1'b1;
    case (state)
      S_P_AA:   acmd = '{op: OP_MUL, a: amin, b: amin};
      S_P_VTRI: acmd = '{op: OP_DIV, a: t0, b: jw};
      S_P_TJA:  acmd = '{op: OP_DIV, a: amin, b: jw};
      S_E_JV: begin
        if (ev <= vtri) acmd = '{op: OP_MUL, a: jw, b: ev};
        else            acmd = '{op: OP_DIV, a: ev, b: amin};
      end
      S_E_SQ: begin
        if (tri_shape) acmd = '{op: OP_SQRT, a: t0, b: '0};
        else           acmd = '{op: OP_SUB, a: t0, b: tja};
      end
      S_E_TJ:   acmd = '{op: OP_DIV, a: ap, b: jw};
      S_E_T1:   acmd = '{op: OP_ADD, a: tj, b: tj};
      S_E_T2:   acmd = '{op: OP_ADD, a: t0, b: ta};
      S_E_DACC: acmd = '{op: OP_MUL17, a: ev, b: tacc};
      S_E_D2:   acmd = '{op: OP_ADD, a: dacc, b: dacc};
      S_E_DC:   acmd = '{op: OP_SUB, a: d, b: d2};
      S_E_TC:   acmd = '{op: OP_DIV, a: dc, b: ev};
      S_E_M1:   acmd = '{op: OP_ADD, a: tacc, b: tacc};
      S_E_M2:   acmd = '{op: OP_ADD, a: t0, b: tcsel};
      default:  alu_need = 1'b0;
    endcase
  end

  assign alu_start = alu_need && !issued;

  // segment table for the output stage
  plan_out_t seg_out;
  logic signed [31:0] acc_s, jerk_s;

  always_comb begin
    acc_s  = neg ? -$signed(ap) : $signed(ap);
    jerk_s = neg ? -$signed(jw) : $signed(jw);
    seg_out.segment_index = seg;
    seg_out.plan_status   = stretched ? ST_STRETCH : ST_OK;
    seg_out.planned_time  = sat31(mt);
    seg_out.segment_total = 3'd7;
    seg_out.last          = (seg == 3'd6);
    seg_out.duration      = sat31(tj);
    seg_out.start_accel   = '0;
    seg_out.segment_jerk  = '0;
    case (seg)
      3'd0: seg_out.segment_jerk = jerk_s;
      3'd1: begin
        seg_out.duration    = sat31(ta);
        seg_out.start_accel = acc_s;
      end
      3'd2: begin
        seg_out.start_accel  = acc_s;
        seg_out.segment_jerk = -jerk_s;
      end
      3'd3: seg_out.duration = sat31(tcsel);
      3'd4: seg_out.segment_jerk = -jerk_s;
      3'd5: begin
        seg_out.duration    = sat31(ta);
        seg_out.start_accel = -acc_s;
      end
      default: begin
        seg_out.start_accel  = -acc_s;
        seg_out.segment_jerk = jerk_s;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      strobe <= 1'b0;
      issued <= 1'b0;
      vlim   <= '0;
      alim   <= '0;
      dlim   <= '0;
      jlim   <= '0;
    end else begin
      state  <= state_next;
      strobe <= 1'b0;

      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_VLIM: vlim <= cfg_data;
          REG_ALIM: alim <= cfg_data;
          REG_DLIM: dlim <= cfg_data;
          REG_JLIM: jlim <= cfg_data;
          default:  ;
        endcase
      end

      // hold the issue flag until the unit answers
      if (alu_start) issued <= 1'b1;
      if (alu_done)  issued <= 1'b0;

      case (state)
        S_IDLE: begin
          if (start) begin
            cmd_r     <= cmd;
            stretched <= 1'b0;
          end
        end
        S_CHK: begin
          d   <= dcalc;
          neg <= diff[32];
          if (bad)      status <= ST_BAD_LIMITS;
          else if (bnd) status <= ST_BOUNDARY;
          else          status <= ST_OK;
        end
        S_SINGLE: begin
          strobe <= 1'b1;
          result <= '{plan_status: status, last: 1'b1, default: '0};
        end
        S_P_AA:   if (alu_done) t0 <= alu_res;
        S_P_VTRI: if (alu_done) vtri <= alu_res;
        S_P_TJA: begin
          if (alu_done) begin
            tja   <= alu_res;
            ev    <= {1'b0, vlim};
            phase <= PH_CEIL0;
          end
        end
        S_E_JV: begin
          if (alu_done) begin
            t0        <= alu_res;
            tri_shape <= (ev <= vtri);
          end
        end
        S_E_SQ: begin
          if (alu_done) begin
            if (tri_shape) begin
              ap <= alu_res;
            end else begin
              ta <= alu_res;
              ap <= amin;
              tj <= tja;
            end
          end
        end
        S_E_TJ: begin
          if (alu_done) begin
            tj <= alu_res;
            ta <= '0;
          end
        end
        S_E_T1:   if (alu_done) t0 <= alu_res;
        S_E_T2:   if (alu_done) tacc <= alu_res;
        S_E_DACC: if (alu_done) dacc <= alu_res;
        S_E_D2:   if (alu_done) d2 <= alu_res;
        S_E_DC:   if (alu_done) dc <= alu_res;
        S_E_TC:   if (alu_done) q <= alu_res;
        S_E_M1:   if (alu_done) t0 <= alu_res;
        S_E_M2:   if (alu_done) mt <= alu_res;
        S_RET: begin
          case (phase)
            PH_CEIL0: begin
              if (d2 <= d) begin
                vceil <= ev;
                phase <= PH_TMIN;
              end else begin
                lo    <= '0;
                hi    <= ev;
                cnt   <= '0;
                ev    <= ev >> 1;
                phase <= PH_BIS1;
              end
            end
            PH_BIS1, PH_BIS2: begin
              lo  <= nlo;
              hi  <= nhi;
              cnt <= cnt + 1'b1;
              ev  <= nmid;
              if (bis_end) begin
                if (phase == PH_BIS1) begin
                  vceil <= nmid;
                  phase <= PH_TMIN;
                end else begin
                  phase <= PH_FINAL;
                end
              end
            end
            PH_TMIN: begin
              // feasible only when the request exceeds the minimum time
              if (reqpos && requ > mt) begin
                lo    <= 32'd1;
                hi    <= vceil;
                cnt   <= '0;
                ev    <= 32'((33'd1 + 33'(vceil)) >> 1);
                phase <= PH_BIS2;
              end else begin
                stretched <= reqpos;
                phase     <= PH_FINAL;
              end
            end
            default: seg <= '0;
          endcase
        end
        S_EMIT: begin
          strobe <= 1'b1;
          result <= seg_out;
          seg    <= seg + 1'b1;
        end
        default: ;
      endcase
    end
  end

  property p_accept_busy;
    @(posedge clk) disable iff (rst) (start && !busy) |=> busy;
  endproperty
  a_accept_busy: assert property (p_accept_busy) else $error("item accepted but not busy");

  property p_last_ends;
    @(posedge clk) disable iff (rst) (strobe && result.last) |-> !busy ##1 !strobe;
  endproperty
  a_last_ends: assert property (p_last_ends) else $error("plan did not end after last");

  property p_segments_run;
    @(posedge clk) disable iff (rst)
      (strobe && !result.last) |=>
        strobe && result.segment_index == $past(result.segment_index) + 3'd1;
  endproperty
  a_segments_run: assert property (p_segments_run) else $error("segment sequence broken");

  property p_no_issue_idle;
    @(posedge clk) disable iff (rst) (state == S_IDLE) |-> !alu_start;
  endproperty
  a_no_issue_idle: assert property (p_no_issue_idle) else $error("unit started while idle");

endmodule

[tb/scurve_move_planner_checker.sv]
// Checker for the move planner: tracks the limits, predicts each plan and compares results.
`timescale 1ns / 1ps
module scurve_move_planner_checker (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic               busy,
  input  smp_pkg::plan_in_t  cmd,
  input  logic               strobe,
  input  smp_pkg::plan_out_t result,
  input  logic               cfg_we,
  input  logic [1:0]         cfg_index,
  input  logic [30:0]        cfg_data,
  output int                 errors,
  output int                 outstanding
);
  import smp_pkg::*;

  typedef logic [63:0] qv_t;
  localparam qv_t QSAT = 64'hFFFF_FFFF;
  localparam qv_t LIM31 = 64'h7FFF_FFFF;

  qv_t vel_lim, acc_lim, dec_lim, jerk_lim;
  plan_out_t segments_due[$];

  function automatic qv_t q_add(qv_t a, qv_t b);
    q_add = (a + b > QSAT) ? QSAT : a + b;
  endfunction

  function automatic qv_t q_sub(qv_t a, qv_t b);
    q_sub = (a > b) ? a - b : 64'd0;
  endfunction

  function automatic qv_t q_mul(qv_t a, qv_t b);
    qv_t p;
    p = (a * b) >> 16;
    q_mul = (p > QSAT) ? QSAT : p;
  endfunction

  function automatic qv_t q_div(qv_t a, qv_t b);
    qv_t p;
    if (b == 0) return QSAT;
    p = (a << 16) / b;
    q_div = (p > QSAT) ? QSAT : p;
  endfunction

  function automatic qv_t q_sqrt(qv_t x);
    qv_t n, r, bt;
    n = x << 16;
    r = 0;
    bt = 64'd1 << 48;
    while (bt > n) bt = bt >> 2;
    while (bt != 0) begin
      if (n >= r + bt) begin
        n = n - (r + bt);
        r = (r >> 1) + bt;
      end else begin
        r = r >> 1;
      end
      bt = bt >> 2;
    end
    q_sqrt = r;
  endfunction

  // Ramp time, constant-accel time and peak accel of one acceleration phase.
  function automatic void ramp_shape(input qv_t v, input qv_t j, input qv_t a,
                                     output qv_t tj, output qv_t ta, output qv_t ap);
    if (v <= q_div(q_mul(a, a), j)) begin
      ap = q_sqrt(q_mul(j, v));
      tj = q_div(ap, j);
      ta = 0;
    end else begin
      ap = a;
      tj = q_div(a, j);
      ta = q_sub(q_div(v, a), q_div(a, j));
    end
  endfunction

  function automatic void ramp_span(input qv_t v, input qv_t j, input qv_t a,
                                    output qv_t tacc, output qv_t dacc);
    qv_t tj, ta, ap, p;
    ramp_shape(v, j, a, tj, ta, ap);
    tacc = q_add(q_add(tj, tj), ta);
    p = (v * tacc) >> 17;
    dacc = (p > QSAT) ? QSAT : p;
  endfunction

  function automatic qv_t total_time(qv_t v, qv_t j, qv_t a, qv_t d);
    qv_t tacc, dacc, dc, tc;
    ramp_span(v, j, a, tacc, dacc);
    dc = q_sub(d, q_add(dacc, dacc));
    tc = (dc > 0) ? q_div(dc, v) : 64'd0;
    total_time = q_add(q_add(tacc, tacc), tc);
  endfunction

  function automatic plan_out_t make_seg(int idx, qv_t dur, logic signed [63:0] acc,
                                         logic signed [63:0] jrk, plan_status_t st,
                                         qv_t pt, int tot, bit fin);
    plan_out_t o;
    o.segment_index = idx[2:0];
    o.duration      = (dur > LIM31) ? 31'h7FFF_FFFF : dur[30:0];
    o.start_accel   = acc[31:0];
    o.segment_jerk  = jrk[31:0];
    o.plan_status   = st;
    o.planned_time  = (pt > LIM31) ? 31'h7FFF_FFFF : pt[30:0];
    o.segment_total = tot[2:0];
    o.last          = fin;
    return o;
  endfunction

  // Plan one move and queue the segments it should produce.
  function automatic void plan_move(plan_in_t c);
    qv_t a, d, tacc, dacc, vceil, tmin, v, lo, hi, mid, tj, ta, ap, dc, tc, pt;
    logic signed [63:0] dd, acc, jrk;
    bit neg, stretched;
    plan_status_t st;
    a = (acc_lim < dec_lim) ? acc_lim : dec_lim;
    if (vel_lim == 0 || a == 0 || jerk_lim == 0) begin
      segments_due.push_back(make_seg(0, 0, 0, 0, ST_BAD_LIMITS, 0, 0, 1));
      return;
    end
    if (c.end_velocity != 0 || c.end_acceleration != 0) begin
      segments_due.push_back(make_seg(0, 0, 0, 0, ST_BOUNDARY, 0, 0, 1));
      return;
    end
    dd = 64'(c.target_position) - 64'(c.start_position);
    neg = dd < 0;
    d = neg ? -dd : dd;
    if (d == 0) begin
      segments_due.push_back(make_seg(0, 0, 0, 0, ST_OK, 0, 0, 1));
      return;
    end
    // Largest peak velocity that fits the distance.
    ramp_span(vel_lim, jerk_lim, a, tacc, dacc);
    if (q_add(dacc, dacc) <= d) begin
      vceil = vel_lim;
    end else begin
      lo = 0;
      hi = vel_lim;
      for (int i = 0; i < BISECT_STEPS; i++) begin
        mid = (lo + hi) >> 1;
        ramp_span(mid, jerk_lim, a, tacc, dacc);
        if (q_add(dacc, dacc) < d) lo = mid; else hi = mid;
      end
      vceil = (lo + hi) >> 1;
    end
    // Slow down to meet the requested time, or stretch.
    tmin = total_time(vceil, jerk_lim, a, d);
    stretched = 0;
    if (c.wanted_time > 0 && qv_t'(c.wanted_time) > tmin) begin
      lo = 1;
      hi = vceil;
      for (int i = 0; i < BISECT_STEPS; i++) begin
        mid = (lo + hi) >> 1;
        if (total_time(mid, jerk_lim, a, d) > qv_t'(c.wanted_time)) lo = mid;
        else hi = mid;
      end
      v = (lo + hi) >> 1;
    end else begin
      v = vceil;
      stretched = c.wanted_time > 0;
    end
    ramp_shape(v, jerk_lim, a, tj, ta, ap);
    ramp_span(v, jerk_lim, a, tacc, dacc);
    dc = q_sub(d, q_add(dacc, dacc));
    tc = (v > 0) ? q_div(dc, v) : 64'd0;
    pt = q_add(q_add(tacc, tacc), tc);
    acc = neg ? -$signed(ap) : $signed(ap);
    jrk = neg ? -$signed(jerk_lim) : $signed(jerk_lim);
    st = stretched ? ST_STRETCH : ST_OK;
    segments_due.push_back(make_seg(0, tj, 0, jrk, st, pt, 7, 0));
    segments_due.push_back(make_seg(1, ta, acc, 0, st, pt, 7, 0));
    segments_due.push_back(make_seg(2, tj, acc, -jrk, st, pt, 7, 0));
    segments_due.push_back(make_seg(3, tc, 0, 0, st, pt, 7, 0));
    segments_due.push_back(make_seg(4, tj, 0, -jrk, st, pt, 7, 0));
    segments_due.push_back(make_seg(5, ta, -acc, 0, st, pt, 7, 0));
    segments_due.push_back(make_seg(6, tj, -acc, jrk, st, pt, 7, 1));
  endfunction

  always @(posedge clk) begin
    plan_out_t e;
    if (rst) begin
      vel_lim <= 0;
      acc_lim <= 0;
      dec_lim <= 0;
      jerk_lim <= 0;
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (reg_index_t'(cfg_index))
          REG_VLIM: vel_lim <= qv_t'(cfg_data);
          REG_ALIM: acc_lim <= qv_t'(cfg_data);
          REG_DLIM: dec_lim <= qv_t'(cfg_data);
          REG_JLIM: jerk_lim <= qv_t'(cfg_data);
          default: ;
        endcase
      end
      if (start && !busy) plan_move(cmd);
      if (strobe) begin
        if (segments_due.size() == 0) begin
          $error("unexpected result, segment_index %0d", result.segment_index);
          errors++;
        end else begin
          e = segments_due.pop_front();
          if (result.segment_index !== e.segment_index) begin
            $error("segment_index expected %0d got %0d", e.segment_index,
                   result.segment_index);
            errors++;
          end
          if (result.duration !== e.duration) begin
            $error("duration expected %0d got %0d", e.duration, result.duration);
            errors++;
          end
          if (result.start_accel !== e.start_accel) begin
            $error("start_accel expected %0d got %0d", e.start_accel, result.start_accel);
            errors++;
          end
          if (result.segment_jerk !== e.segment_jerk) begin
            $error("segment_jerk expected %0d got %0d", e.segment_jerk,
                   result.segment_jerk);
            errors++;
          end
          if (result.plan_status !== e.plan_status) begin
            $error("plan_status expected %0d got %0d", e.plan_status, result.plan_status);
            errors++;
          end
          if (result.planned_time !== e.planned_time) begin
            $error("planned_time expected %0d got %0d", e.planned_time,
                   result.planned_time);
            errors++;
          end
          if (result.segment_total !== e.segment_total) begin
            $error("segment_total expected %0d got %0d", e.segment_total,
                   result.segment_total);
            errors++;
          end
          if (result.last !== e.last) begin
            $error("last expected %0d got %0d", e.last, result.last);
            errors++;
          end
        end
      end
    end
    outstanding <= segments_due.size();
  end

endmodule

[tb/scurve_move_planner_tb.sv]
// Testbench top for the move planner: clock, reset, limits, move stimulus and verdict.
`timescale 1ns / 1ps
module scurve_move_planner_tb;
  import smp_pkg::*;

  localparam int IDLE_LIMIT = 200000;   // well above the time of one full plan
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  plan_in_t    cmd;
  logic        strobe;
  plan_out_t   result;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [30:0] cfg_data;
  int          errors;
  int          outstanding;
  int          quiet_cycles;
  int          burst_left;

  scurve_move_planner u_top (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .strobe(strobe), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  scurve_move_planner_checker u_checker (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd),
    .strobe(strobe), .result(result),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .outstanding(outstanding)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // Watchdog: end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst || (start && !busy) || strobe) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= IDLE_LIMIT) begin
        $display("Mismatches found");
        $finish;
      end
    end
  end

  // Write all four limits back to back; drop the enable only after the last one.
  task automatic set_limits(logic [30:0] vl, logic [30:0] al, logic [30:0] dl,
                            logic [30:0] jl);
    cfg_we <= 1; cfg_index <= REG_VLIM; cfg_data <= vl;
    @(posedge clk);
    cfg_index <= REG_ALIM; cfg_data <= al;
    @(posedge clk);
    cfg_index <= REG_DLIM; cfg_data <= dl;
    @(posedge clk);
    cfg_index <= REG_JLIM; cfg_data <= jl;
    @(posedge clk);
    cfg_we <= 0;
  endtask

  // Hold off until every segment is back, then let the block settle.
  task automatic drain();
    start <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // Present one item and hold it until it is taken.
  task automatic send(plan_in_t c);
    start <= 1;
    cmd <= c;
    forever begin
      @(negedge clk);
      if (!busy) break;
    end
    @(posedge clk);
  endtask

  // Send one item, then maybe open a gap between bursts.
  task automatic send_paced(plan_in_t c);
    send(c);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 6);
      if ($urandom_range(0, 3) != 0) begin
        start <= 0;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  endtask

  function automatic plan_in_t move(logic signed [31:0] p0, logic signed [31:0] p1,
                                    logic signed [31:0] t);
    plan_in_t c;
    c.start_position = p0;
    c.target_position = p1;
    c.wanted_time = t;
    c.end_velocity = 0;
    c.end_acceleration = 0;
    return c;
  endfunction

  // Mostly well-formed moves over short spans, with some full-range noise.
  function automatic plan_in_t random_move();
    plan_in_t c;
    if ($urandom_range(0, 4) == 0) begin
      c.start_position = $urandom;
      c.target_position = $urandom;
    end else begin
      c.start_position = $signed($urandom_range(0, 40 << 16)) - (20 <<< 16);
      c.target_position = c.start_position +
                          ($signed($urandom_range(0, 20 << 16)) - (10 <<< 16));
    end
    if ($urandom_range(0, 19) == 0) c.target_position = c.start_position;
    case ($urandom_range(0, 9))
      0:       c.wanted_time = 0;
      1:       c.wanted_time = -$signed($urandom_range(1, 32'h7FFF_FFFF));
      2:       c.wanted_time = $urandom;
      3:       c.wanted_time = $urandom_range(1, 2000);
      default: c.wanted_time = $urandom_range(1, 30 << 16);
    endcase
    c.end_velocity = 0;
    c.end_acceleration = 0;
    case ($urandom_range(0, 19))
      0: c.end_velocity = $urandom;
      1: c.end_acceleration = $urandom;
      default: ;
    endcase
    return c;
  endfunction

  initial begin
    plan_in_t c;
    rst = 1;
    start = 0;
    cmd = '0;
    cfg_we = 0;
    cfg_index = REG_VLIM;
    cfg_data = 0;
    burst_left = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // Limits still zero after reset: every plan is rejected.
    send(move(0, ONE, 0));
    send(move(-ONE, ONE, 5 * ONE));
    drain();

    // One limit missing at a time.
    set_limits(31'h2_0000, 31'h0, 31'h3_0000, 31'hA_0000);
    send(move(0, ONE, 0));
    drain();
    set_limits(31'h2_0000, 31'h4_0000, 31'h3_0000, 31'h0);
    send(move(0, ONE, 0));
    drain();

    // Moderate limits: directed corner moves.
    set_limits(31'h2_0000, 31'h4_0000, 31'h3_0000, 31'hA_0000);
    send(move(ONE, ONE, 0));                                 // null move
    c = move(0, ONE, 0); c.end_velocity = 32'h8000_0001;     // nonzero end velocity
    send(c);
    c = move(0, ONE, 0); c.end_acceleration = 32'h7FFF_FFFF; // nonzero end accel
    send(c);
    send(move(0, 3 * ONE, 0));                               // fastest
    send(move(0, 3 * ONE, -ONE));                            // negative request: fastest
    send(move(0, 3 * ONE, 10 * ONE));                        // meets request
    send(move(0, 3 * ONE, 1));                               // stretched
    send(move(3 * ONE, -2 * ONE, 8 * ONE));                  // negative direction
    send(move(0, 32'sd1, 0));                                // one-LSB move
    send(move(32'sh8000_0000, 32'sh7FFF_FFFF, 0));           // largest distance
    send(move(32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF));
    send(move(0, 50 * ONE, 40 * ONE));                       // long cruise
    drain();

    // Extreme limits.
    set_limits(31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF);
    send(move(0, 5 * ONE, 0));
    send(move(32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF));
    drain();
    set_limits(31'h1, 31'h1, 31'h7FFF_FFFF, 31'h1);
    send(move(0, ONE, 0));
    send(move(ONE, 0, 3 * ONE));
    drain();

    // Random moves under three limit settings.
    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0: set_limits(31'h2_0000, 31'h4_0000, 31'h3_0000, 31'hA_0000);
        1: set_limits(31'($urandom_range(1, 31'h7FFF_FFFF)), 31'($urandom_range(1, 8 << 16)),
                      31'($urandom_range(1, 31'h7FFF_FFFF)), 31'($urandom_range(1, 50 << 16)));
        default: set_limits(31'h8000, 31'h7FFF_FFFF, 31'h1_0000, 31'h7FFF_FFFF);
      endcase
      for (int k = 0; k < 33; k++) send_paced(random_move());
      drain();
    end

    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
